### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared geometry, character codes, operation codes and the command record
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int CELL_W = $clog2(CELLS);
  localparam int SWP_W  = $clog2(CELLS + 1);

  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int TAB_W    = 4;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_COL_W  = 7;
  localparam int IN_ROW_W  = 5;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [TAB_W-1:0]  MAX_TAB         = 4'd8;
  localparam logic [ATTR_W-1:0] DEF_ATTR_RESET  = 8'd15;
  localparam logic [TAB_W-1:0]  TAB_WIDTH_RESET = 4'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRINT = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_ATTR = 2'd0,
    CFG_TAB_WIDTH    = 2'd1
  } cfg_e;

  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_BACKSPACE,
    K_TAB,
    K_READ,
    K_CLEAR,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  ch;
    logic               set_pos;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ATTR_W-1:0]  attr;
    logic [TAB_W-1:0]   tab_cnt;
  } cmd_t;

  function automatic logic [CELL_W-1:0] cell_index(logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row);
    return CELL_W'(row * COLUMNS + col);
  endfunction

endpackage

### hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console of 80 by 25 cells with a cursor, fed by requests.
//
// Requests enter on the in_valid_i/in_ready_o channel: print a character,
// read one cell, clear the screen or do nothing. Every request gives exactly one result
// on out_valid_o/out_ready_i with the cursor after the request, the cell read
// and a flag for a scroll. Configuration writes on the cfg channel set the
// default attribute (index 0) and the tab width (index 1); they are always
// taken and are meant for idle periods.
// A decoded request waits in a two-entry queue; the back end runs one at a
// time. A tab writes a space into each cell that it advances over. A scroll
// moves the cell memory one entry per cycle through its single write port,
// and a clear rewrites every cell of the screen.
// After reset the back end zeroes the memory, and in_ready_o is low until it
// is done. A stalled receiver holds the result register, the back end then
// waits, and the queue fills before in_ready_o drops.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tcw_pkg::FUNC_W-1:0]      func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      character_i,
  input  logic                            use_position_i,
  input  logic [tcw_pkg::IN_COL_W-1:0]    column_i,
  input  logic [tcw_pkg::IN_ROW_W-1:0]    row_i,
  input  logic [tcw_pkg::ATTR_W-1:0]      attribute_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column_o,
  output logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::CHAR_W-1:0]      cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]      cell_attribute_o,
  output logic                            scrolled_o
);

  logic          q_push, q_not_full, q_pop, q_not_empty, busy;
  tcw_pkg::cmd_t push_cmd, pop_cmd;

  tcw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .character_i    (character_i),
    .use_position_i (use_position_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .attribute_i    (attribute_i),
    .q_ready_i      (q_not_full),
    .busy_i         (busy),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  tcw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_cmd_i  (push_cmd),
    .not_full_o  (q_not_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_cmd_o   (pop_cmd)
  );

  tcw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_not_empty),
    .q_cmd_i          (pop_cmd),
    .q_pop_o          (q_pop),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .cell_char_o      (cell_char_o),
    .cell_attribute_o (cell_attribute_o),
    .scrolled_o       (scrolled_o)
  );

endmodule

### hw/rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console writer front end
// Holds the configuration registers, accepts requests and turns each one into
// a command with a resolved kind, saturated position, attribute and tab count.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tcw_pkg::FUNC_W-1:0]     func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]     character_i,
  input  logic                           use_position_i,
  input  logic [tcw_pkg::IN_COL_W-1:0]   column_i,
  input  logic [tcw_pkg::IN_ROW_W-1:0]   row_i,
  input  logic [tcw_pkg::ATTR_W-1:0]     attribute_i,
  input  logic                           q_ready_i,
  input  logic                           busy_i,
  output logic                           q_push_o,
  output tcw_pkg::cmd_t                  q_cmd_o
);

  logic [tcw_pkg::ATTR_W-1:0] def_attr_q, def_attr_d;
  logic [tcw_pkg::TAB_W-1:0]  tab_width_q, tab_width_d;
  logic [tcw_pkg::COL_W-1:0]  sat_col;
  logic [tcw_pkg::ROW_W-1:0]  sat_row;
  logic [tcw_pkg::ATTR_W-1:0] print_attr;
  logic [tcw_pkg::TAB_W-1:0]  tab_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready_i && !busy_i;
  assign q_push_o    = in_valid_i && in_ready_o;

  always_comb begin
    def_attr_d  = def_attr_q;
    tab_width_d = tab_width_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == tcw_pkg::CFG_DEFAULT_ATTR) begin
        def_attr_d = cfg_data_i;
      end else if (cfg_index_i == tcw_pkg::CFG_TAB_WIDTH) begin
        tab_width_d = cfg_data_i[tcw_pkg::TAB_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q  <= tcw_pkg::DEF_ATTR_RESET;
      tab_width_q <= tcw_pkg::TAB_WIDTH_RESET;
    end else begin
      def_attr_q  <= def_attr_d;
      tab_width_q <= tab_width_d;
    end
  end

  always_comb begin
    sat_col = (column_i >= tcw_pkg::COLUMNS) ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)
                                             : tcw_pkg::COL_W'(column_i);
    sat_row = (row_i >= tcw_pkg::ROWS) ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                       : tcw_pkg::ROW_W'(row_i);
    print_attr = (attribute_i == '0) ? def_attr_q : attribute_i;
    tab_cnt    = (tab_width_q > tcw_pkg::MAX_TAB) ? tcw_pkg::MAX_TAB : tab_width_q;
  end

  always_comb begin
    q_cmd_o         = '0;
    q_cmd_o.ch      = character_i;
    q_cmd_o.col     = sat_col;
    q_cmd_o.row     = sat_row;
    q_cmd_o.attr    = print_attr;
    q_cmd_o.tab_cnt = tab_cnt;
    unique case (tcw_pkg::func_e'(func_i))
      tcw_pkg::FUNC_PRINT: begin
        q_cmd_o.set_pos = use_position_i;
        if (character_i == tcw_pkg::CH_NEWLINE) begin
          q_cmd_o.kind = tcw_pkg::K_NEWLINE;
        end else if (character_i == tcw_pkg::CH_BACKSPACE) begin
          q_cmd_o.kind = tcw_pkg::K_BACKSPACE;
        end else if (character_i == tcw_pkg::CH_TAB) begin
          q_cmd_o.kind = tcw_pkg::K_TAB;
        end else begin
          q_cmd_o.kind = tcw_pkg::K_CHAR;
        end
      end
      tcw_pkg::FUNC_READ: begin
        q_cmd_o.kind = tcw_pkg::K_READ;
      end
      tcw_pkg::FUNC_CLEAR: begin
        q_cmd_o.kind = tcw_pkg::K_CLEAR;
        q_cmd_o.attr = def_attr_q;
      end
      default: begin
        q_cmd_o.kind = tcw_pkg::K_NOP;
      end
    endcase
  end

endmodule

### hw/rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// Text console writer command queue
// Two-entry queue that decouples request decoding from command execution.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t push_cmd_i,
  output logic          not_full_o,
  input  logic          pop_i,
  output logic          not_empty_o,
  output tcw_pkg::cmd_t pop_cmd_o
);

  tcw_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign not_full_o  = (count_q != 2'd2);
  assign not_empty_o = (count_q != 2'd0);
  assign pop_cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### hw/rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the cell memory and the cursor, executes queued commands one at a time
// including scroll, clear and the clearing pass after reset, and holds the
// result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  tcw_pkg::cmd_t                   q_cmd_i,
  output logic                            q_pop_o,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column_o,
  output logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::CHAR_W-1:0]      cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]      cell_attribute_o,
  output logic                            scrolled_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_CLEAR,
    S_DONE
  } state_e;

  localparam int MOVE_CELLS = tcw_pkg::CELLS - tcw_pkg::COLUMNS;

  state_e                      state_q, state_d;
  tcw_pkg::cmd_t               cmd_q, cmd_d;
  logic [tcw_pkg::COL_W-1:0]   cur_col_q, cur_col_d;
  logic [tcw_pkg::ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [tcw_pkg::TAB_W-1:0]   tab_q, tab_d;
  logic [tcw_pkg::SWP_W-1:0]   sweep_q, sweep_d;
  logic                        scrolled_q, scrolled_d;

  logic                        out_valid_q, out_valid_d;
  logic [tcw_pkg::OUT_COL_W-1:0] out_col_q, out_col_d;
  logic [tcw_pkg::OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [tcw_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
  logic [tcw_pkg::ATTR_W-1:0]  out_attr_q, out_attr_d;
  logic                        out_scr_q, out_scr_d;

  logic [15:0]                 mem_q [tcw_pkg::CELLS];
  logic [15:0]                 rdata_q;
  logic                        mem_we, mem_re;
  logic [tcw_pkg::CELL_W-1:0]  mem_waddr, mem_raddr;
  logic [15:0]                 mem_wdata;

  logic [tcw_pkg::COL_W-1:0]   adv_col, prev_col;
  logic [tcw_pkg::ROW_W-1:0]   adv_row, prev_row;
  logic                        out_free, start, load_out;

  assign out_free = !out_valid_q || out_ready_i;
  assign start    = q_valid_i && ((state_q == S_IDLE) || ((state_q == S_DONE) && out_free));
  assign q_pop_o  = start;
  assign busy_o   = (state_q == S_INIT);

  always_comb begin
    if (cur_col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
      adv_col = '0;
      adv_row = cur_row_q + tcw_pkg::ROW_W'(1);
    end else begin
      adv_col = cur_col_q + tcw_pkg::COL_W'(1);
      adv_row = cur_row_q;
    end
    if (cur_col_q == '0) begin
      prev_col = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
      prev_row = cur_row_q - tcw_pkg::ROW_W'(1);
    end else begin
      prev_col = cur_col_q - tcw_pkg::COL_W'(1);
      prev_row = cur_row_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    tab_d      = tab_q;
    sweep_d    = sweep_q;
    scrolled_d = scrolled_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    load_out   = 1'b0;

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = tcw_pkg::CELL_W'(sweep_q);
        if (sweep_q == tcw_pkg::SWP_W'(tcw_pkg::CELLS - 1)) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + tcw_pkg::SWP_W'(1);
        end
      end
      S_IDLE: begin
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (cmd_q.kind)
          tcw_pkg::K_CHAR: begin
            mem_we    = 1'b1;
            mem_waddr = tcw_pkg::cell_index(cur_col_q, cur_row_q);
            mem_wdata = {cmd_q.attr, cmd_q.ch};
            cur_col_d = adv_col;
            cur_row_d = adv_row;
            if (adv_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS)) begin
              state_d = S_SCROLL;
            end
          end
          tcw_pkg::K_NEWLINE: begin
            cur_col_d = '0;
            cur_row_d = cur_row_q + tcw_pkg::ROW_W'(1);
            if (cur_row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
              state_d = S_SCROLL;
            end
          end
          tcw_pkg::K_BACKSPACE: begin
            if ((cur_col_q != '0) || (cur_row_q != '0)) begin
              mem_we    = 1'b1;
              mem_waddr = tcw_pkg::cell_index(prev_col, prev_row);
              mem_wdata = {cmd_q.attr, tcw_pkg::CH_SPACE};
              cur_col_d = prev_col;
              cur_row_d = prev_row;
            end
          end
          tcw_pkg::K_TAB: begin
            if (tab_q == '0) begin
              if (cur_row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS)) begin
                state_d = S_SCROLL;
              end
            end else begin
              state_d   = S_EXEC;
              mem_we    = (cur_row_q != tcw_pkg::ROW_W'(tcw_pkg::ROWS));
              mem_waddr = tcw_pkg::cell_index(cur_col_q, cur_row_q);
              mem_wdata = {cmd_q.attr, tcw_pkg::CH_SPACE};
              cur_col_d = adv_col;
              cur_row_d = adv_row;
              tab_d     = tab_q - tcw_pkg::TAB_W'(1);
            end
          end
          tcw_pkg::K_READ: begin
            mem_re    = 1'b1;
            mem_raddr = tcw_pkg::cell_index(cmd_q.col, cmd_q.row);
          end
          tcw_pkg::K_CLEAR: begin
            cur_col_d = '0;
            cur_row_d = '0;
            sweep_d   = '0;
            state_d   = S_CLEAR;
          end
          default: begin
          end
        endcase
        if (state_d == S_SCROLL) begin
          sweep_d    = '0;
          scrolled_d = 1'b1;
          cur_row_d  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        end
      end
      S_SCROLL: begin
        mem_re    = (sweep_q < tcw_pkg::SWP_W'(MOVE_CELLS));
        mem_raddr = tcw_pkg::CELL_W'(sweep_q + tcw_pkg::SWP_W'(tcw_pkg::COLUMNS));
        mem_we    = (sweep_q != '0);
        mem_waddr = tcw_pkg::CELL_W'(sweep_q - tcw_pkg::SWP_W'(1));
        mem_wdata = (sweep_q <= tcw_pkg::SWP_W'(MOVE_CELLS)) ? rdata_q : '0;
        if (sweep_q == tcw_pkg::SWP_W'(tcw_pkg::CELLS)) begin
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + tcw_pkg::SWP_W'(1);
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = tcw_pkg::CELL_W'(sweep_q);
        mem_wdata = {cmd_q.attr, tcw_pkg::CH_SPACE};
        if (sweep_q == tcw_pkg::SWP_W'(tcw_pkg::CELLS - 1)) begin
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + tcw_pkg::SWP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start) begin
      cmd_d      = q_cmd_i;
      tab_d      = q_cmd_i.tab_cnt;
      scrolled_d = 1'b0;
      state_d    = S_EXEC;
      if (q_cmd_i.set_pos) begin
        cur_col_d = q_cmd_i.col;
        cur_row_d = q_cmd_i.row;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    out_scr_d   = out_scr_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_col_d   = tcw_pkg::OUT_COL_W'(cur_col_q);
      out_row_d   = tcw_pkg::OUT_ROW_W'(cur_row_q);
      out_scr_d   = scrolled_q;
      if (cmd_q.kind == tcw_pkg::K_READ) begin
        out_char_d = rdata_q[7:0];
        out_attr_d = rdata_q[15:8];
      end else begin
        out_char_d = '0;
        out_attr_d = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      tab_q       <= '0;
      sweep_q     <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      tab_q       <= tab_d;
      sweep_q     <= sweep_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
    out_scr_q  <= out_scr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_column_o  = out_col_q;
  assign cursor_row_o     = out_row_q;
  assign cell_char_o      = out_char_q;
  assign cell_attribute_o = out_attr_q;
  assign scrolled_o       = out_scr_q;

endmodule
